// File: rtl/tss_pkg.sv
// Shared definitions for the touch sampling service: frame and buffer sizes,
// derived widths, command and reply codes, and the divider handshake structs.
// No dependencies.
package tss_pkg;

   localparam int LINES_PER_FRAME = 263;
   localparam int MAX_SAMPLES     = 4;
   localparam int BUFFER_WORDS    = 16;

   // fixed field widths of the ports
   localparam int REPLY_W    = 26;
   localparam int SCANLINE_W = 9;
   localparam int VALUE_W    = 16;
   localparam int SLOT_W     = 4;
   localparam int CMD_W      = 8;

   // request word layout
   localparam int SLOT_LSB   = 16;
   localparam int FINAL_BIT  = 24;
   localparam int CLEAR_BIT  = 25;

   // derived widths
   localparam int LINE_W  = $clog2(LINES_PER_FRAME);
   localparam int CNT_W   = $clog2(MAX_SAMPLES + 1);
   localparam int IDX_W   = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
   localparam int NUM_RAW = ((MAX_SAMPLES - 1) * LINES_PER_FRAME >= 1) ?
                            $clog2((MAX_SAMPLES - 1) * LINES_PER_FRAME + 1) : 1;
   localparam int NUM_W   = (NUM_RAW > LINE_W) ? NUM_RAW : LINE_W;
   localparam int DCNT_W  = $clog2(NUM_W);

   // input opcodes
   localparam logic OP_REQUEST = 1'b0;
   localparam logic OP_TICK    = 1'b1;

   // commands held in the high byte of buffer word 0
   localparam logic [CMD_W-1:0] CMD_MANUAL      = 8'd0;
   localparam logic [CMD_W-1:0] CMD_SETUP       = 8'd1;
   localparam logic [CMD_W-1:0] CMD_STOP        = 8'd2;
   localparam logic [CMD_W-1:0] CMD_MANUAL_COND = 8'd3;

   // reply words
   localparam logic [REPLY_W-1:0] RPL_MANUAL      = 26'h3008000;
   localparam logic [REPLY_W-1:0] RPL_SETUP_BUSY  = 26'h3008103;
   localparam logic [REPLY_W-1:0] RPL_SETUP_BAD   = 26'h3008102;
   localparam logic [REPLY_W-1:0] RPL_SETUP_OK    = 26'h3008100;
   localparam logic [REPLY_W-1:0] RPL_STOP_IDLE   = 26'h3008203;
   localparam logic [REPLY_W-1:0] RPL_STOP_OK     = 26'h3008200;
   localparam logic [REPLY_W-1:0] RPL_MANUAL_COND = 26'h3008300;
   localparam logic [REPLY_W-1:0] RPL_AUTO        = 26'h3009000;

   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] num;
      logic [CNT_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [NUM_W-1:0] quot;
   } div_rsp_type;

endpackage

// File: rtl/tss_divider.sv
// Restoring divider, one quotient bit per cycle, for sample line spacing.
// Depends on tss_pkg (widths and handshake structs).
module tss_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  tss_pkg::div_req_type req,
   output tss_pkg::div_rsp_type rsp
);

   logic                       run_ff, run_in;
   logic                       done_ff, done_in;
   logic [tss_pkg::DCNT_W-1:0] cnt_ff, cnt_in;
   logic [tss_pkg::CNT_W-1:0]  rem_ff, rem_in;
   logic [tss_pkg::CNT_W-1:0]  den_ff, den_in;
   logic [tss_pkg::NUM_W-1:0]  quot_ff, quot_in;
   logic [tss_pkg::CNT_W:0]    trial;
   logic                       fits;

   // shift next numerator bit into the partial remainder
   assign trial = {rem_ff, quot_ff[tss_pkg::NUM_W-1]};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quot_in = quot_ff;
      if (req.start) begin
         run_in  = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         den_in  = req.den;
         quot_in = req.num;
      end else if (run_ff) begin
         rem_in  = fits ? tss_pkg::CNT_W'(trial - {1'b0, den_ff})
                        : trial[tss_pkg::CNT_W-1:0];
         quot_in = {quot_ff[tss_pkg::NUM_W-2:0], fits};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == tss_pkg::DCNT_W'(tss_pkg::NUM_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quot = quot_ff;

endmodule

// File: rtl/touch_sampling_service_top.sv
// Top level of the touch sampling service: request buffer, command sequencer,
// sample line schedule and scanline match. Depends on tss_pkg, tss_divider.
//
// Usage
//   Input: drive req_opcode, req_request_word and req_scanline with start high;
//   the word is taken at a rising edge where start is high and busy is low.
//   Request words (opcode 0) gather slots 0 and 1 of the buffer; a word with
//   the final flag runs the command in the high byte of slot 0. Ticks
//   (opcode 1) compare the scanline against the stored sample lines.
//   Output: rsp_valid is high for exactly one cycle with rsp_reply_code and
//   rsp_take_sample; the receiver cannot stall, so every reply is taken then.
//   Per word
//   - request word without final flag: taken while busy stays low, no reply.
//   - manual, stop and rejected setup: word decoded in S_CMD, reply registered.
//   - accepted setup: one divider pass per sample line, each pass NUM_W
//     quotient bits, handed over through div_start and done; the reply
//     follows the pass for the last line.
//   - tick: one stored line compared per cycle, up to MAX_SAMPLES lines.
//   busy stays high until the word is finished; a new word may be taken in
//   the same cycle its predecessor's reply is shown.
//   Reset clears the buffer, schedule and sequencer at once; no sweep.
module touch_sampling_service_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_opcode,
   input  logic [tss_pkg::REPLY_W-1:0]   req_request_word,
   input  logic [tss_pkg::SCANLINE_W-1:0] req_scanline,
   output logic                          rsp_valid,
   output logic [tss_pkg::REPLY_W-1:0]   rsp_reply_code,
   output logic                          rsp_take_sample
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_CMD  = 2'd1;
   localparam logic [1:0] S_DIV  = 2'd2;
   localparam logic [1:0] S_SCAN = 2'd3;

   logic [1:0] state_ff, state_in;

   // Only slots 0 and 1 of the request buffer are ever read by a command;
   // words for the other slots (all below BUFFER_WORDS) are taken and dropped.
   logic [tss_pkg::VALUE_W-1:0] word0_ff, word0_in;
   logic [tss_pkg::VALUE_W-1:0] word1_ff, word1_in;

   logic                           active_ff, active_in;
   logic [tss_pkg::CNT_W-1:0]      count_ff, count_in;
   logic [tss_pkg::CNT_W-1:0]      n_ff, n_in;
   logic [tss_pkg::IDX_W-1:0]      idx_ff, idx_in;
   logic [tss_pkg::NUM_W-1:0]      num_ff, num_in;
   logic [tss_pkg::SCANLINE_W-1:0] line_ff, line_in;
   logic [tss_pkg::LINE_W-1:0]     lines_ff [tss_pkg::MAX_SAMPLES];
   logic                           line_we;
   logic [tss_pkg::LINE_W-1:0]     line_wdata;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [tss_pkg::REPLY_W-1:0] rsp_code_ff, rsp_code_in;
   logic                        rsp_take_ff, rsp_take_in;
   logic                        div_start_ff, div_start_in;

   tss_pkg::div_req_type div_req;
   tss_pkg::div_rsp_type div_rsp;

   logic                          accept;
   logic [tss_pkg::SLOT_W-1:0]    slot;
   logic [tss_pkg::VALUE_W-1:0]   value;
   logic [tss_pkg::CMD_W-1:0]     cmd;
   logic [tss_pkg::CMD_W-1:0]     n_req;
   logic [tss_pkg::LINE_W:0]      line_sum;
   logic [tss_pkg::LINE_W-1:0]    line_wrap;

   assign accept = start && (state_ff == S_IDLE);
   assign slot   = req_request_word[tss_pkg::SLOT_LSB +: tss_pkg::SLOT_W];
   assign value  = req_request_word[tss_pkg::VALUE_W-1:0];
   assign cmd    = word0_ff[tss_pkg::VALUE_W-1 -: tss_pkg::CMD_W];
   assign n_req  = word0_ff[tss_pkg::CMD_W-1:0];

   // offset + spacing is below twice the frame, so one subtract wraps it
   assign line_sum  = {1'b0, word1_ff[tss_pkg::LINE_W-1:0]}
                    + {1'b0, div_rsp.quot[tss_pkg::LINE_W-1:0]};
   assign line_wrap = (line_sum >= (tss_pkg::LINE_W + 1)'(tss_pkg::LINES_PER_FRAME))
                    ? tss_pkg::LINE_W'(line_sum
                        - (tss_pkg::LINE_W + 1)'(tss_pkg::LINES_PER_FRAME))
                    : line_sum[tss_pkg::LINE_W-1:0];
   assign line_wdata = line_wrap;

   assign div_req.start = div_start_ff;
   assign div_req.num   = num_ff;
   assign div_req.den   = n_ff;

   tss_divider u_divider (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   always_comb begin
      state_in     = state_ff;
      word0_in     = word0_ff;
      word1_in     = word1_ff;
      active_in    = active_ff;
      count_in     = count_ff;
      n_in         = n_ff;
      idx_in       = idx_ff;
      num_in       = num_ff;
      line_in      = line_ff;
      line_we      = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_code_in  = rsp_code_ff;
      rsp_take_in  = rsp_take_ff;
      div_start_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_opcode == tss_pkg::OP_TICK) begin
                  line_in = req_scanline;
                  idx_in  = '0;
                  if (count_ff != '0) state_in = S_SCAN;
               end else begin
                  // clear first, then store the slot
                  if (req_request_word[tss_pkg::CLEAR_BIT]) begin
                     word0_in = '0;
                     word1_in = '0;
                  end
                  if (slot == tss_pkg::SLOT_W'(0)) word0_in = value;
                  if (slot == tss_pkg::SLOT_W'(1)) word1_in = value;
                  if (req_request_word[tss_pkg::FINAL_BIT]) state_in = S_CMD;
               end
            end
         end
         S_CMD: begin
            state_in = S_IDLE;
            unique case (cmd)
               tss_pkg::CMD_MANUAL: begin
                  rsp_valid_in = 1'b1;
                  rsp_code_in  = tss_pkg::RPL_MANUAL;
                  rsp_take_in  = 1'b1;
               end
               tss_pkg::CMD_MANUAL_COND: begin
                  rsp_valid_in = 1'b1;
                  rsp_code_in  = tss_pkg::RPL_MANUAL_COND;
                  rsp_take_in  = 1'b1;
               end
               tss_pkg::CMD_STOP: begin
                  rsp_valid_in = 1'b1;
                  rsp_take_in  = 1'b0;
                  if (active_ff) begin
                     count_in    = '0;
                     active_in   = 1'b0;
                     rsp_code_in = tss_pkg::RPL_STOP_OK;
                  end else begin
                     rsp_code_in = tss_pkg::RPL_STOP_IDLE;
                  end
               end
               tss_pkg::CMD_SETUP: begin
                  if (active_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_code_in  = tss_pkg::RPL_SETUP_BUSY;
                     rsp_take_in  = 1'b0;
                  end else if (n_req == '0
                               || n_req > tss_pkg::CMD_W'(tss_pkg::MAX_SAMPLES)
                               || word1_ff >= tss_pkg::VALUE_W'(tss_pkg::LINES_PER_FRAME))
                  begin
                     rsp_valid_in = 1'b1;
                     rsp_code_in  = tss_pkg::RPL_SETUP_BAD;
                     rsp_take_in  = 1'b0;
                  end else begin
                     // launch the first spacing division, line 0 at the offset
                     n_in         = n_req[tss_pkg::CNT_W-1:0];
                     idx_in       = '0;
                     num_in       = '0;
                     div_start_in = 1'b1;
                     state_in     = S_DIV;
                  end
               end
               default: begin
                  // unknown command: drop silently
               end
            endcase
         end
         S_DIV: begin
            if (div_rsp.done) begin
               line_we = 1'b1;
               if (tss_pkg::CNT_W'(idx_ff) == n_ff - 1'b1) begin
                  count_in     = n_ff;
                  active_in    = 1'b1;
                  rsp_valid_in = 1'b1;
                  rsp_code_in  = tss_pkg::RPL_SETUP_OK;
                  rsp_take_in  = 1'b0;
                  state_in     = S_IDLE;
               end else begin
                  // advance to the next line: numerator grows by one frame
                  idx_in       = idx_ff + 1'b1;
                  num_in       = num_ff + tss_pkg::NUM_W'(tss_pkg::LINES_PER_FRAME);
                  div_start_in = 1'b1;
               end
            end
         end
         S_SCAN: begin
            if (tss_pkg::SCANLINE_W'(lines_ff[idx_ff]) == line_ff) begin
               rsp_valid_in = 1'b1;
               rsp_code_in  = tss_pkg::RPL_AUTO | tss_pkg::REPLY_W'(idx_ff);
               rsp_take_in  = 1'b1;
               state_in     = S_IDLE;
            end else if (tss_pkg::CNT_W'(idx_ff) == count_ff - 1'b1) begin
               state_in = S_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         word0_ff     <= '0;
         word1_ff     <= '0;
         active_ff    <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         div_start_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         word0_ff     <= word0_in;
         word1_ff     <= word1_in;
         active_ff    <= active_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         div_start_ff <= div_start_in;
      end
      n_ff        <= n_in;
      idx_ff      <= idx_in;
      num_ff      <= num_in;
      line_ff     <= line_in;
      rsp_code_ff <= rsp_code_in;
      rsp_take_ff <= rsp_take_in;
   end

   // sample line schedule, written one line per divider pass
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < tss_pkg::MAX_SAMPLES; i++) lines_ff[i] <= '0;
      end else if (line_we) begin
         lines_ff[idx_ff] <= line_wdata;
      end
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_reply_code  = rsp_code_ff;
   assign rsp_take_sample = rsp_take_ff;

   // schedule is live exactly when a nonzero count is stored
   a_active_count: assert property (@(posedge clock) disable iff (reset)
      active_ff == (count_ff != '0))
      else $error("auto_active and sample_count disagree");

   // a reply only comes out of work done while busy
   a_reply_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("reply without a word in progress");

   // replies never come in consecutive cycles
   a_reply_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("two replies back to back");

   // divider results only land while the sequencer waits for them
   a_div_in_setup: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> state_ff == S_DIV)
      else $error("divider finished outside setup");

endmodule

// File: test/tb_top.sv
// Self-checking bench for touch_sampling_service_top: directed and random service
// words and scanline ticks, replies checked against an in-bench behavioral predictor.
// Depends on tss_pkg and the RTL of touch_sampling_service_top.
module tb_top;

   // slowest accepted item is an accepted setup; sender pauses stay far below
   // QUIET_LIMIT, so a quiet stretch that long can only mean a hang
   localparam int QUIET_LIMIT  = 2000;
   localparam int SETTLE_TICKS = 64;
   localparam int RANDOM_ITEMS = 550;

   typedef struct packed {
      logic [tss_pkg::REPLY_W-1:0] code;
      logic                        take;
   } reply_type;

   logic                           clock;
   logic                           reset            = 1'b1;
   logic                           start            = 1'b0;
   logic                           req_opcode       = tss_pkg::OP_REQUEST;
   logic [tss_pkg::REPLY_W-1:0]    req_request_word = '0;
   logic [tss_pkg::SCANLINE_W-1:0] req_scanline     = '0;
   logic                           busy;
   logic                           rsp_valid;
   logic [tss_pkg::REPLY_W-1:0]    rsp_reply_code;
   logic                           rsp_take_sample;

   // predicted copy of the service state
   logic [tss_pkg::VALUE_W-1:0] word_store [tss_pkg::BUFFER_WORDS];
   logic [tss_pkg::LINE_W-1:0]  sched_line [tss_pkg::MAX_SAMPLES];
   int                          sched_count = 0;
   bit                          auto_on     = 1'b0;

   reply_type expected_replies[$];

   int items_sent    = 0;
   int replies_seen  = 0;
   int auto_hits     = 0;
   int setups_taken  = 0;
   int mismatches    = 0;
   int burst_left    = 1;
   int quiet_cycles  = 0;

   touch_sampling_service_top uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_opcode       (req_opcode),
      .req_request_word (req_request_word),
      .req_scanline     (req_scanline),
      .rsp_valid        (rsp_valid),
      .rsp_reply_code   (rsp_reply_code),
      .rsp_take_sample  (rsp_take_sample)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Work out the reply, if any, of one accepted word and queue it.
   function automatic void predict_service(logic op, logic [tss_pkg::REPLY_W-1:0] w,
                                           logic [tss_pkg::SCANLINE_W-1:0] line);
      logic [tss_pkg::CMD_W-1:0] cmd;
      int                        n;
      int                        offset;
      if (op == tss_pkg::OP_TICK) begin
         // first stored line that matches wins
         for (int i = 0; i < sched_count; i++) begin
            if (line == tss_pkg::SCANLINE_W'(sched_line[i])) begin
               expected_replies.push_back(
                  '{tss_pkg::RPL_AUTO | tss_pkg::REPLY_W'(i), 1'b1});
               auto_hits++;
               return;
            end
         end
         return;
      end
      if (w[tss_pkg::CLEAR_BIT]) begin
         foreach (word_store[i]) word_store[i] = '0;
      end
      if (int'(w[tss_pkg::SLOT_LSB +: tss_pkg::SLOT_W]) < tss_pkg::BUFFER_WORDS) begin
         word_store[w[tss_pkg::SLOT_LSB +: tss_pkg::SLOT_W]] = w[tss_pkg::VALUE_W-1:0];
      end
      if (!w[tss_pkg::FINAL_BIT]) return;
      cmd = word_store[0][15:8];
      case (cmd)
         tss_pkg::CMD_MANUAL: begin
            expected_replies.push_back('{tss_pkg::RPL_MANUAL, 1'b1});
         end
         tss_pkg::CMD_MANUAL_COND: begin
            expected_replies.push_back('{tss_pkg::RPL_MANUAL_COND, 1'b1});
         end
         tss_pkg::CMD_SETUP: begin
            n      = int'(word_store[0][7:0]);
            offset = int'(word_store[1]);
            if (auto_on) begin
               expected_replies.push_back('{tss_pkg::RPL_SETUP_BUSY, 1'b0});
            end else if (n == 0 || n > tss_pkg::MAX_SAMPLES
                         || offset >= tss_pkg::LINES_PER_FRAME) begin
               expected_replies.push_back('{tss_pkg::RPL_SETUP_BAD, 1'b0});
            end else begin
               // spread n lines evenly over the frame from the offset line
               for (int i = 0; i < n; i++) begin
                  sched_line[i] = tss_pkg::LINE_W'(
                     (offset + (i * tss_pkg::LINES_PER_FRAME) / n)
                     % tss_pkg::LINES_PER_FRAME);
               end
               sched_count = n;
               auto_on     = 1'b1;
               setups_taken++;
               expected_replies.push_back('{tss_pkg::RPL_SETUP_OK, 1'b0});
            end
         end
         tss_pkg::CMD_STOP: begin
            // stored lines stay; only the count and the active flag drop
            if (!auto_on) begin
               expected_replies.push_back('{tss_pkg::RPL_STOP_IDLE, 1'b0});
            end else begin
               sched_count = 0;
               auto_on     = 1'b0;
               expected_replies.push_back('{tss_pkg::RPL_STOP_OK, 1'b0});
            end
         end
         default: ;
      endcase
   endfunction

   // Build a service word; the unused bits 20-23 get random values.
   function automatic logic [tss_pkg::REPLY_W-1:0] service_word(
      bit clr, bit fin, logic [tss_pkg::SLOT_W-1:0] slot,
      logic [tss_pkg::VALUE_W-1:0] value);
      return {clr, fin, 4'($urandom), slot, value};
   endfunction

   // Hold start low, then wait out the pause given by n.
   task automatic pause_sender(int n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // Present one word, wait for it to be taken, predict it, then maybe idle.
   task automatic send_item(logic op, logic [tss_pkg::REPLY_W-1:0] w,
                            logic [tss_pkg::SCANLINE_W-1:0] line);
      req_opcode       <= op;
      req_request_word <= w;
      req_scanline     <= line;
      start            <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_service(op, w, line);
      items_sent++;
      burst_left--;
      if (burst_left <= 0) begin
         // mostly short bursts, now and then a long stretch with no gaps
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 8);
         pause_sender($urandom_range(1, 12));
      end
   endtask

   task automatic send_request(bit clr, bit fin, logic [tss_pkg::SLOT_W-1:0] slot,
                               logic [tss_pkg::VALUE_W-1:0] value);
      send_item(tss_pkg::OP_REQUEST, service_word(clr, fin, slot, value),
                tss_pkg::SCANLINE_W'($urandom));
   endtask

   task automatic send_tick(logic [tss_pkg::SCANLINE_W-1:0] line);
      send_item(tss_pkg::OP_TICK, tss_pkg::REPLY_W'($urandom), line);
   endtask

   // Hold the sender off until every predicted reply has been seen.
   task automatic drain_replies();
      start <= 1'b0;
      @(posedge clock);
      while (expected_replies.size() != 0) @(posedge clock);
   endtask

   task automatic test_after_reset();
      // empty schedule: stored lines are zero but nothing may match
      send_tick('0);
      send_tick('1);
      send_request(1'b1, 1'b1, 4'd0, 16'h0000);
      send_request(1'b1, 1'b1, 4'd0, {tss_pkg::CMD_STOP, 8'h00});
   endtask

   task automatic test_manual_sampling();
      // all ones: clear, slot 15 written, final, word 0 now zero
      send_item(tss_pkg::OP_REQUEST, '1, '1);
      send_request(1'b1, 1'b1, 4'd0, {tss_pkg::CMD_MANUAL_COND, 8'hFF});
      send_request(1'b0, 1'b1, 4'd15, 16'hFFFF);
   endtask

   task automatic test_setup_rejects();
      send_request(1'b1, 1'b1, 4'd0, {tss_pkg::CMD_SETUP, 8'd0});
      send_request(1'b1, 1'b1, 4'd0, {tss_pkg::CMD_SETUP, 8'(tss_pkg::MAX_SAMPLES + 1)});
      send_request(1'b1, 1'b0, 4'd1, 16'(tss_pkg::LINES_PER_FRAME));
      send_request(1'b0, 1'b1, 4'd0, {tss_pkg::CMD_SETUP, 8'(tss_pkg::MAX_SAMPLES)});
      send_request(1'b0, 1'b0, 4'd1, 16'hFFFF);
      send_request(1'b0, 1'b1, 4'd0, {tss_pkg::CMD_SETUP, 8'd1});
   endtask

   task automatic test_auto_schedule();
      // last line of the frame as offset, so the schedule wraps
      send_request(1'b1, 1'b0, 4'd1, 16'(tss_pkg::LINES_PER_FRAME - 1));
      send_request(1'b0, 1'b1, 4'd0, {tss_pkg::CMD_SETUP, 8'(tss_pkg::MAX_SAMPLES)});
      send_request(1'b0, 1'b1, 4'd0, {tss_pkg::CMD_SETUP, 8'(tss_pkg::MAX_SAMPLES)});
      for (int i = 0; i < sched_count; i++)
         send_tick(tss_pkg::SCANLINE_W'(sched_line[i]));
      send_tick(tss_pkg::SCANLINE_W'(tss_pkg::LINES_PER_FRAME));
      send_tick('0);
   endtask

   task automatic test_stop_and_restart();
      send_request(1'b1, 1'b1, 4'd0, {tss_pkg::CMD_STOP, 8'h00});
      send_tick(tss_pkg::SCANLINE_W'(tss_pkg::LINES_PER_FRAME - 1));
      // final flag on the offset word this time
      send_request(1'b0, 1'b0, 4'd0, {tss_pkg::CMD_SETUP, 8'd1});
      send_request(1'b0, 1'b1, 4'd1, 16'd0);
      send_tick('0);
      drain_replies();
   endtask

   task automatic test_ignored_words();
      send_request(1'b1, 1'b1, 4'd0, 16'hFFFF);
      send_request(1'b0, 1'b1, 4'd0, {8'(tss_pkg::CMD_MANUAL_COND + 1), 8'h00});
   endtask

   task automatic test_random_traffic();
      int goal;
      int kind;
      int n;
      int rounds;
      bit clr;
      logic [tss_pkg::VALUE_W-1:0] offset;
      goal   = items_sent + RANDOM_ITEMS;
      rounds = 0;
      while (items_sent < goal) begin
         kind = $urandom_range(0, 99);
         clr  = 1'($urandom);
         if (kind < 15) begin
            send_request(clr, 1'b1, 4'd0,
                         {($urandom_range(0, 1) ? tss_pkg::CMD_MANUAL_COND
                                                : tss_pkg::CMD_MANUAL), 8'($urandom)});
         end else if (kind < 42) begin
            // stop first most of the time so that setups actually land
            if (auto_on && $urandom_range(0, 9) < 6)
               send_request(1'b0, 1'b1, 4'd0, {tss_pkg::CMD_STOP, 8'($urandom)});
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                            : $urandom_range(1, tss_pkg::MAX_SAMPLES);
            offset = ($urandom_range(0, 7) == 0)
                   ? tss_pkg::VALUE_W'($urandom)
                   : tss_pkg::VALUE_W'($urandom_range(0, tss_pkg::LINES_PER_FRAME - 1));
            if ($urandom_range(0, 1)) begin
               send_request(clr, 1'b0, 4'd1, offset);
               send_request(1'b0, 1'b1, 4'd0, {tss_pkg::CMD_SETUP, 8'(n)});
            end else begin
               send_request(clr, 1'b0, 4'd0, {tss_pkg::CMD_SETUP, 8'(n)});
               send_request(1'b0, 1'b1, 4'd1, offset);
            end
         end else if (kind < 52) begin
            send_request(clr, 1'b1, 4'd0, {tss_pkg::CMD_STOP, 8'($urandom)});
         end else if (kind < 85) begin
            // aim most ticks at the live schedule
            n = $urandom_range(1, 6);
            repeat (n) begin
               if (sched_count > 0 && $urandom_range(0, 9) < 7)
                  send_tick(tss_pkg::SCANLINE_W'(
                     sched_line[$urandom_range(0, sched_count - 1)]));
               else
                  send_tick(tss_pkg::SCANLINE_W'($urandom));
            end
         end else if (kind < 92) begin
            send_request(clr, 1'b1, 4'($urandom),
                         {8'($urandom_range(tss_pkg::CMD_MANUAL_COND + 1, 255)),
                          8'($urandom)});
         end else begin
            send_item(1'($urandom), tss_pkg::REPLY_W'($urandom),
                      tss_pkg::SCANLINE_W'($urandom));
         end
         rounds++;
         if (rounds % 97 == 0) drain_replies();
      end
   endtask

   // Compare every strobed reply with the oldest prediction.
   always @(posedge clock) begin
      reply_type want;
      if (!reset && rsp_valid) begin
         replies_seen++;
         if (expected_replies.size() == 0) begin
            $error("unexpected reply: rsp_reply_code %h rsp_take_sample %b",
                   rsp_reply_code, rsp_take_sample);
            mismatches++;
         end else begin
            want = expected_replies.pop_front();
            if (rsp_reply_code !== want.code) begin
               $error("rsp_reply_code: expected %h, got %h", want.code, rsp_reply_code);
               mismatches++;
            end
            if (rsp_take_sample !== want.take) begin
               $error("rsp_take_sample: expected %b, got %b", want.take, rsp_take_sample);
               mismatches++;
            end
         end
      end
   end

   // Count cycles with neither a word taken nor a reply shown.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
         $display("** touch_sampling_service_top: FAILED **");
         $finish;
      end
   end

   initial begin
      foreach (word_store[i]) word_store[i] = '0;
      foreach (sched_line[i]) sched_line[i] = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_after_reset();
      test_manual_sampling();
      test_setup_rejects();
      test_auto_schedule();
      test_stop_and_restart();
      test_ignored_words();
      test_random_traffic();

      // let the last replies and any trailing tick scan finish
      drain_replies();
      repeat (SETTLE_TICKS) @(posedge clock);

      $display("covered %0d words: %0d replies, %0d accepted setups, %0d auto samples",
               items_sent, replies_seen, setups_taken, auto_hits);
      $display("directed edges of slot, offset, count and scanline, then random traffic");
      if (mismatches == 0 && expected_replies.size() == 0)
         $display("** touch_sampling_service_top: PASSED **");
      else
         $display("** touch_sampling_service_top: FAILED **");
      $finish;
   end

endmodule

// File: touch_sampling_service_top.f
rtl/tss_pkg.sv
rtl/tss_divider.sv
rtl/touch_sampling_service_top.sv
test/tb_top.sv
